// ----- hdl/int_array_deque_with_sort_unit_assert.svh -----
// Assertion macros for the deque with sort unit.
// Used by int_array_deque_with_sort_unit; no other dependencies.
`ifndef INT_ARRAY_DEQUE_WITH_SORT_UNIT_ASSERT_SVH
`define INT_ARRAY_DEQUE_WITH_SORT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define IADS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("iads assertion failed");
`define IADS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("iads assertion failed");
`else
`define IADS_ASSERT(label, clk, rst, prop)
`define IADS_ASSERT_NR(label, clk, prop)
`endif

`endif

// ----- hdl/iads_pkg.sv -----
// Package for the deque with sort unit: item types, opcodes, status codes,
// state encoding and default depth. No dependencies.
package iads_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_WIDTH    = 32;

   localparam logic [2:0] OP_PUSH      = 3'd0;
   localparam logic [2:0] OP_POP_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK  = 3'd2;
   localparam logic [2:0] OP_SORT      = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [6:0]         element_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SORT_LOAD,
      S_SORT_KEY,
      S_SORT_SHIFT,
      S_SORT_PLACE
   } state_type;

endpackage

// ----- hdl/iads_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module iads_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/int_array_deque_with_sort_unit.sv -----
// Top level of the deque with in-place insertion sort.
// Depends on iads_pkg, iads_ram and int_array_deque_with_sort_unit_assert.svh.
//
// Elements live in a ring in one RAM (one write, one registered read port).
// An item is taken when start is high and busy is low; its result appears
// on rsp_item for one cycle with rsp_strobe and cannot be held off. Push,
// clear, unused opcodes, failed pops and sorts of fewer than two elements
// answer in the cycle after acceptance; a successful pop waits in S_POP
// for the registered RAM read. Sort is insertion sort through the RAM
// port: per key, S_SORT_LOAD and S_SORT_KEY fetch it, S_SORT_SHIFT does
// one compare per visit, S_SORT_PLACE puts it at the front. No clearing pass.
module int_array_deque_with_sort_unit #(
   parameter int DEPTH = iads_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iads_pkg::req_type req_item,
   output logic              rsp_strobe,
   output iads_pkg::rsp_type rsp_item
);

   `include "int_array_deque_with_sort_unit_assert.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = iads_pkg::DATA_WIDTH;

   iads_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       i_ff, i_in;
   logic [AW-1:0]       j_ff, j_in;
   logic [DW-1:0]       key_ff, key_in;
   logic                strobe_ff, strobe_in;
   iads_pkg::rsp_type   rsp_ff, rsp_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [DW-1:0]       wr_data, rd_data;
   logic                accept;
   logic                quick_op;
   logic                sort_adv;
   logic [CW+6:0]       count_ext;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] idx);
      logic [AW:0] s;
      s = {1'b0, head} + {1'b0, idx};
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   iads_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy     = (state_ff != iads_pkg::S_IDLE);
   assign accept   = start && !busy;
   assign quick_op = accept &&
                     (req_item.opcode inside {iads_pkg::OP_PUSH, iads_pkg::OP_CLEAR});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= iads_pkg::S_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      key_in    = key_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = phys(head_ff, j_ff);
      wr_data   = key_ff;
      rd_addr   = phys(head_ff, i_ff);
      sort_adv  = 1'b0;

      case (state_ff)
         iads_pkg::S_IDLE: begin
            if (accept) begin
               rsp_in.popped_value = '0;
               rsp_in.status       = iads_pkg::STAT_OK;
               case (req_item.opcode)
                  iads_pkg::OP_PUSH: begin
                     strobe_in = 1'b1;
                     if (count_ff >= CW'(DEPTH)) begin
                        rsp_in.status = iads_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(head_ff, count_ff[AW-1:0]);
                        wr_data  = req_item.push_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  iads_pkg::OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = iads_pkg::STAT_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
                        count_in = count_ff - CW'(1);
                        state_in = iads_pkg::S_POP;
                     end
                  end
                  iads_pkg::OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = iads_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        rd_addr  = phys(head_ff, count_in[AW-1:0]);
                        state_in = iads_pkg::S_POP;
                     end
                  end
                  iads_pkg::OP_SORT: begin
                     if (count_ff < CW'(2)) begin
                        strobe_in = 1'b1;
                     end else begin
                        i_in     = AW'(1);
                        state_in = iads_pkg::S_SORT_LOAD;
                     end
                  end
                  iads_pkg::OP_CLEAR: begin
                     strobe_in = 1'b1;
                     count_in  = '0;
                     head_in   = '0;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         iads_pkg::S_POP: begin
            strobe_in           = 1'b1;
            rsp_in.popped_value = rd_data;
            rsp_in.status       = iads_pkg::STAT_OK;
            state_in            = iads_pkg::S_IDLE;
         end
         iads_pkg::S_SORT_LOAD: begin
            rd_addr  = phys(head_ff, i_ff);
            state_in = iads_pkg::S_SORT_KEY;
         end
         iads_pkg::S_SORT_KEY: begin
            key_in   = rd_data;
            j_in     = i_ff;
            rd_addr  = phys(head_ff, i_ff - AW'(1));
            state_in = iads_pkg::S_SORT_SHIFT;
         end
         iads_pkg::S_SORT_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, j_ff);
            if ($signed(rd_data) > $signed(key_ff)) begin
               wr_data = rd_data;
               j_in    = j_ff - AW'(1);
               if (j_ff == AW'(1)) begin
                  state_in = iads_pkg::S_SORT_PLACE;
               end else begin
                  rd_addr = phys(head_ff, j_ff - AW'(2));
               end
            end else begin
               wr_data  = key_ff;
               sort_adv = 1'b1;
            end
         end
         iads_pkg::S_SORT_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, j_ff);
            wr_data  = key_ff;
            sort_adv = 1'b1;
         end
         default: begin
            state_in = iads_pkg::S_IDLE;
         end
      endcase

      if (sort_adv) begin
         if (CW'(i_ff) + CW'(1) == count_ff) begin
            strobe_in           = 1'b1;
            rsp_in.popped_value = '0;
            rsp_in.status       = iads_pkg::STAT_OK;
            state_in            = iads_pkg::S_IDLE;
         end else begin
            i_in     = i_ff + AW'(1);
            state_in = iads_pkg::S_SORT_LOAD;
         end
      end

      count_ext            = (CW+7)'(count_in);
      rsp_in.element_count = count_ext[6:0];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `IADS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `IADS_ASSERT(a_head_bound, clock, reset, {1'b0, head_ff} < (AW+1)'(DEPTH))
   `IADS_ASSERT(a_strobe_idle, clock, reset, rsp_strobe |-> !busy)
   `IADS_ASSERT(a_quick_ops, clock, reset, quick_op |=> rsp_strobe)

endmodule
